// File: rtl/rsmp_pkg.sv
// ----------------------------------------------------------------------------
// rsmp_pkg: shared constants and types of the stereo polyphase resampler
// Holds sizes, field codes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
`default_nettype none
package rsmp_pkg;

  localparam int TAPS       = 16;
  localparam int PHASE_BITS = 10;
  localparam int POS_BITS   = 24;
  localparam int COEF_BITS  = 16;
  localparam int GAIN_FRAC  = 12;
  localparam int SAMP_W     = 16;
  localparam int MIX_W      = 24;
  localparam int GAIN_W     = 16;
  localparam int INC_W      = 32;
  localparam int FRAC_W     = 24;
  localparam int FETCH_W    = 24;
  localparam int ADDR_IN_W  = 14;
  localparam int TAP_W      = $clog2(TAPS);
  localparam int COEF_AW    = PHASE_BITS + TAP_W;
  localparam int COEF_DEPTH = 1 << COEF_AW;
  localparam int ACC_W      = SAMP_W + COEF_BITS + TAP_W;
  localparam int PROD_W     = ACC_W + GAIN_W + 1;
  localparam int RND_SH     = COEF_BITS - 1 + GAIN_FRAC;
  localparam int STEP_W     = INC_W - FRAC_W + 1;
  localparam int PSUM_W     = POS_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(PSUM_W + 1);

  // input kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_COEF    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // register indexes
  localparam logic [2:0] REG_INC    = 3'd0;
  localparam logic [2:0] REG_COUNT  = 3'd1;
  localparam logic [2:0] REG_LOOP   = 3'd2;
  localparam logic [2:0] REG_GAIN   = 3'd3;
  localparam logic [2:0] REG_STEREO = 3'd4;

  typedef struct packed {
    logic             capture;
    logic             shift;
    logic             issue;
    logic [TAP_W-1:0] tap;
    logic             gain_mul;
    logic             finish;
    logic             div_start;
    logic             div_wr;
    logic             load_out;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_busy;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/rsmp_div.sv
// ----------------------------------------------------------------------------
// rsmp_div: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; returns the remainder.
// ----------------------------------------------------------------------------
`default_nettype none
module rsmp_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [rsmp_pkg::PSUM_W-1:0]   dividend_i,
  input  logic [rsmp_pkg::POS_BITS-1:0] divisor_i,
  output logic [rsmp_pkg::POS_BITS-1:0] rem_o,
  output logic                          done_o
);
  import rsmp_pkg::*;

  logic [PSUM_W-1:0]    num_q, num_d;
  logic [POS_BITS-1:0]  rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic [PSUM_W-1:0]    trial;

  // shift in one bit, subtract when it fits
  always_comb begin
    trial  = {rem_q, num_q[PSUM_W-1]};
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = DIV_CNT_W'(PSUM_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[PSUM_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = POS_BITS'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[POS_BITS-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign rem_o  = rem_q;
  assign done_o = !busy_q && !start_i;

endmodule
`default_nettype wire

// File: rtl/rsmp_dp.sv
// ----------------------------------------------------------------------------
// rsmp_dp: resampler datapath
// Registers, history lines, coefficient memory, shared MAC lanes, gain,
// saturation, position update and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module rsmp_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rsmp_pkg::cmd_t          cmd_i,
  output rsmp_pkg::status_t       status_o,
  input  logic [1:0]              kind_i,
  input  logic [111:0]            in_data_i,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_index_i,
  input  logic [31:0]             cfg_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [71:0]             out_data_o,
  output logic                    out_fin_o
);
  import rsmp_pkg::*;

  // configuration
  logic [INC_W-1:0]    inc_q;
  logic [POS_BITS-1:0] count_reg_q;
  logic                loop_q, stereo_q;
  logic [GAIN_W-1:0]   gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q       <= INC_W'(32'h0100_0000);
      count_reg_q <= POS_BITS'(1);
      loop_q      <= 1'b0;
      gain_q      <= GAIN_W'(4096);
      stereo_q    <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_INC:    inc_q       <= cfg_data_i;
        REG_COUNT:  count_reg_q <= cfg_data_i[POS_BITS-1:0];
        REG_LOOP:   loop_q      <= cfg_data_i[0];
        REG_GAIN:   gain_q      <= cfg_data_i[GAIN_W-1:0];
        REG_STEREO: stereo_q    <= cfg_data_i[0];
        default:    ;
      endcase
    end
  end

  // captured request fields
  logic signed [SAMP_W-1:0] sl_q, sr_q;
  logic signed [MIX_W-1:0]  ml_q, mr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sl_q <= in_data_i[15:0];
      sr_q <= stereo_q ? in_data_i[31:16] : in_data_i[15:0];
      ml_q <= in_data_i[55:32];
      mr_q <= in_data_i[79:56];
    end
  end

  // coefficient memory
  logic signed [COEF_BITS-1:0] coef_mem [COEF_DEPTH];
  logic signed [COEF_BITS-1:0] coef_q;
  logic [COEF_AW-1:0]          rd_addr;
  logic                        coef_we;

  assign coef_we = cmd_i.capture && (kind_i == KIND_COEF);

  always_ff @(posedge clk_i) begin
    if (coef_we) coef_mem[in_data_i[80 +: COEF_AW]] <= in_data_i[109:94];
    coef_q <= coef_mem[rd_addr];
  end

  // playback state
  logic [POS_BITS-1:0] pos_q, llp_q;
  logic [FRAC_W-1:0]   frac_q;
  logic                llv_q;
  logic                load_hist;
  logic [PSUM_W-1:0]   psum_q;
  logic [POS_BITS-1:0] cnt_q;
  logic [FRAC_W-1:0]   frac_next_q;
  logic                fin_q;
  logic [INC_W:0]      frac_sum;
  logic [POS_BITS-1:0] div_rem;
  logic                div_done;

  assign load_hist = !llv_q || (pos_q != llp_q);
  assign frac_sum  = {1'b0, inc_q} + (INC_W + 1)'(frac_q);
  assign rd_addr   = {frac_q[FRAC_W-1 -: PHASE_BITS], cmd_i.tap};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      frac_q <= '0;
      llp_q  <= '0;
      llv_q  <= 1'b0;
    end else begin
      if (cmd_i.capture && (kind_i == KIND_RESTART)) begin
        pos_q  <= '0;
        frac_q <= '0;
        llv_q  <= 1'b0;
      end
      if (cmd_i.shift && load_hist) begin
        llp_q <= pos_q;
        llv_q <= 1'b1;
      end
      if (cmd_i.finish) begin
        frac_q <= frac_next_q;
        if (psum_q >= {1'b0, cnt_q}) begin
          if (!loop_q) pos_q <= '0;
        end else begin
          pos_q <= psum_q[POS_BITS-1:0];
        end
      end
      if (cmd_i.div_wr) pos_q <= div_rem;
    end
  end

  // history lines
  logic signed [SAMP_W-1:0] hist_l [TAPS];
  logic signed [SAMP_W-1:0] hist_r [TAPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        hist_l[i] <= '0;
        hist_r[i] <= '0;
      end
    end else if (cmd_i.shift && load_hist) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        hist_l[i] <= hist_l[i+1];
        hist_r[i] <= hist_r[i+1];
      end
      hist_l[TAPS-1] <= sl_q;
      hist_r[TAPS-1] <= sr_q;
    end
  end

  // MAC lanes: tap select and coefficient read, then accumulate
  logic signed [SAMP_W-1:0] hl_q, hr_q;
  logic                     acc_en_q;
  logic signed [ACC_W-1:0]  accl_q, accr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) acc_en_q <= 1'b0;
    else         acc_en_q <= cmd_i.issue;
  end

  always_ff @(posedge clk_i) begin
    hl_q <= hist_l[cmd_i.tap];
    hr_q <= hist_r[cmd_i.tap];
    if (cmd_i.shift) begin
      accl_q <= '0;
      accr_q <= '0;
    end else if (acc_en_q) begin
      accl_q <= accl_q + ACC_W'(hl_q * coef_q);
      accr_q <= accr_q + ACC_W'(hr_q * coef_q);
    end
  end

  // gain multiply and position sum
  logic signed [PROD_W-1:0] pl_q, pr_q;
  logic signed [GAIN_W:0]   gain_s;

  assign gain_s = $signed({1'b0, gain_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.gain_mul) begin
      pl_q        <= PROD_W'(accl_q * gain_s);
      pr_q        <= PROD_W'(accr_q * gain_s);
      psum_q      <= PSUM_W'(pos_q) + PSUM_W'(frac_sum[INC_W:FRAC_W]);
      frac_next_q <= frac_sum[FRAC_W-1:0];
      cnt_q       <= (count_reg_q == '0) ? POS_BITS'(1) : count_reg_q;
    end
  end

  // round, add to mix, saturate
  localparam int SUM_W = PROD_W - RND_SH + 1;
  logic signed [PROD_W-1:0] rl, rr;
  logic signed [SUM_W-1:0]  tl, tr;
  logic signed [MIX_W-1:0]  res_l_q, res_r_q;

  function automatic logic signed [MIX_W-1:0] sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi, lo;
    hi = SUM_W'(8388607);
    lo = -SUM_W'(8388608);
    if (v > hi) return MIX_W'(24'h7FFFFF);
    else if (v < lo) return MIX_W'(24'h800000);
    else return v[MIX_W-1:0];
  endfunction

  always_comb begin
    rl = (pl_q + (PROD_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
    rr = (pr_q + (PROD_W'(1) <<< (RND_SH - 1))) >>> RND_SH;
    tl = SUM_W'(rl[SUM_W-1:0]) + SUM_W'(ml_q);
    tr = SUM_W'(rr[SUM_W-1:0]) + SUM_W'(mr_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      res_l_q <= sat(tl);
      res_r_q <= sat(tr);
      fin_q   <= (psum_q >= {1'b0, cnt_q}) && !loop_q;
    end
  end

  // modulo unit for looping wrap
  rsmp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (psum_q),
    .divisor_i  (cnt_q),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  // output register
  logic        ov_q;
  logic [71:0] od_q;
  logic        of_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      od_q <= {FETCH_W'(pos_q), res_r_q, res_l_q};
      of_q <= fin_q;
    end
  end

  assign out_valid_o       = ov_q;
  assign out_data_o        = od_q;
  assign out_fin_o         = of_q;
  assign status_o.need_div = (psum_q >= {1'b0, cnt_q}) && loop_q;
  assign status_o.div_done = div_done;
  assign status_o.out_busy = ov_q && !out_ready_i;

endmodule
`default_nettype wire

// File: rtl/rsmp_ctrl.sv
// ----------------------------------------------------------------------------
// rsmp_ctrl: resampler sequencer
// Takes one request, steps the datapath through shift, taps, gain, wrap, out.
// ----------------------------------------------------------------------------
`default_nettype none
module rsmp_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic [1:0]          kind_i,
  output logic                in_ready_o,
  input  rsmp_pkg::status_t   status_i,
  output rsmp_pkg::cmd_t      cmd_o
);
  import rsmp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_SHIFT, S_MAC, S_DRAIN, S_GAIN, S_SUM, S_DIV, S_OUT
  } state_e;

  state_e           state_q, state_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    tap_d   = tap_q;
    cmd_o   = '0;
    cmd_o.tap = tap_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.capture = accept;
        if (accept && kind_i == KIND_TICK) state_d = S_SHIFT;
      end
      S_SHIFT: begin
        cmd_o.shift = 1'b1;
        tap_d       = '0;
        state_d     = S_MAC;
      end
      S_MAC: begin
        cmd_o.issue = 1'b1;
        tap_d       = tap_q + 1'b1;
        if (tap_q == TAP_W'(TAPS - 1)) state_d = S_DRAIN;
      end
      S_DRAIN: state_d = S_GAIN;
      S_GAIN: begin
        cmd_o.gain_mul = 1'b1;
        state_d        = S_SUM;
      end
      S_SUM: begin
        cmd_o.finish = 1'b1;
        if (status_i.need_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.div_wr = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_OUT: begin
        if (!status_i.out_busy) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tap_q   <= '0;
    end else begin
      state_q <= state_d;
      tap_q   <= tap_d;
    end
  end

endmodule
`default_nettype wire

// File: rtl/polyphase_fir_resampler_stereo_top.sv
// Sequence: a tick request steps through shift, the MAC pass over 16 taps, drain,
//   gain and sum, then the bit-serial remainder unit when a looping wrap needs it.
// Throughput: no new request is taken until the tick result is in the output
//   register; coefficient writes and restarts are taken in the idle state.
// Reset: asynchronous, active low; clears history, position, phase and registers;
//   the coefficient memory is not cleared and must be written before use.
// ----------------------------------------------------------------------------
// polyphase_fir_resampler_stereo_top: stereo 16-tap polyphase resampler
// Sequencer plus datapath with an 8.24 phase accumulator and mix output.
// ----------------------------------------------------------------------------
`default_nettype none
module polyphase_fir_resampler_stereo_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid,
  output logic         s_tready,
  // sample_left, sample_right, mix_left, mix_right, coef_address, coef_value
  input  logic [111:0] s_tdata,
  // kind
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_left, out_right, fetch_position
  output logic [71:0]  m_tdata,
  // finished
  output logic         m_tuser,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_index_i,
  input  logic [31:0]  cfg_data_i
);
  import rsmp_pkg::*;

  cmd_t    cmd;
  status_t status;

  rsmp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_tvalid),
    .kind_i     (s_tuser),
    .in_ready_o (s_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rsmp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .kind_i      (s_tuser),
    .in_data_i   (s_tdata),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_tdata),
    .out_fin_o   (m_tuser)
  );

endmodule
`default_nettype wire

// File: rtl/rsmp_checker.sv
// ----------------------------------------------------------------------------
// rsmp_checker: port-level checks of the resampler
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none
module rsmp_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic [1:0]   s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [71:0]  m_tdata,
  input logic         m_tuser
);
  import rsmp_pkg::*;

  // a tick request occupies the engine
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tuser == KIND_TICK |=> !s_tready)
    else $error("request taken while tick in progress");

  // finished always comes with position zero
  a_fin_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser |-> m_tdata[71:48] == 24'd0)
    else $error("finished with nonzero position");

  // no result appears without a preceding tick in flight
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_tvalid) |-> !$past(s_tready))
    else $error("result without tick");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind polyphase_fir_resampler_stereo_top rsmp_checker u_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire

// File: sim/polyphase_fir_resampler_stereo_top_tb.sv
// ----------------------------------------------------------------------------
// polyphase_fir_resampler_stereo_top_tb: self-checking bench of the resampler
// Loads coefficient rows, plays ticks under several register settings and
// checks mixed outputs, fetch position and finished against a local model.
// ----------------------------------------------------------------------------
`default_nettype none

class mix_scoreboard;
  logic [23:0] hist_l [16];
  logic [23:0] hist_r [16];
  logic signed [15:0] coef [16384];
  logic [31:0] inc;
  logic [23:0] count;
  logic        loop_en;
  logic [15:0] gain;
  logic        stereo;
  logic [23:0] pos;
  logic [23:0] frac;
  logic [23:0] last_pos;
  logic        last_ok;
  logic [72:0] pending [$];
  int          errors;
  int          ticks;

  function new();
    foreach (hist_l[i]) begin
      hist_l[i] = '0;
      hist_r[i] = '0;
    end
    inc = 32'h0100_0000; count = 24'd1; loop_en = 0; gain = 16'd4096; stereo = 1;
    pos = '0; frac = '0; last_pos = '0; last_ok = 0; errors = 0; ticks = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      rsmp_pkg::REG_INC:    inc = v;
      rsmp_pkg::REG_COUNT:  count = v[23:0];
      rsmp_pkg::REG_LOOP:   loop_en = v[0];
      rsmp_pkg::REG_GAIN:   gain = v[15:0];
      rsmp_pkg::REG_STEREO: stereo = v[0];
      default: ;
    endcase
  endfunction

  // apply the gain, round half up, add the mix and saturate one channel
  function logic [23:0] mix_one(longint acc, logic signed [23:0] m);
    longint p;
    longint r;
    p = acc * longint'(gain) + (longint'(1) << 26);
    r = p >>> 27;
    r = r + longint'(m);
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return r[23:0];
  endfunction

  // note an accepted request and queue the result it causes
  function void note_request(logic [1:0] kind, logic [111:0] d);
    logic signed [15:0] sl, sr;
    longint al, ar;
    logic [9:0] ph;
    logic [32:0] f;
    logic [24:0] p;
    logic [23:0] cnt;
    logic fin;
    if (kind == rsmp_pkg::KIND_COEF) begin
      coef[d[93:80]] = d[109:94];
      return;
    end
    if (kind == rsmp_pkg::KIND_RESTART) begin
      pos = '0; frac = '0; last_ok = 0;
      return;
    end
    if (kind != rsmp_pkg::KIND_TICK) return;
    sl = d[15:0];
    sr = stereo ? d[31:16] : d[15:0];
    if (!last_ok || pos != last_pos) begin
      for (int i = 0; i < 15; i++) begin
        hist_l[i] = hist_l[i+1];
        hist_r[i] = hist_r[i+1];
      end
      hist_l[15] = 24'(sl);
      hist_r[15] = 24'(sr);
      last_pos = pos; last_ok = 1;
    end
    ph = frac[23:14];
    al = 0; ar = 0;
    for (int i = 0; i < 16; i++) begin
      al += longint'($signed(hist_l[i][15:0])) * longint'(coef[{ph, 4'(i)}]);
      ar += longint'($signed(hist_r[i][15:0])) * longint'(coef[{ph, 4'(i)}]);
    end
    f = {9'd0, frac} + {1'b0, inc};
    p = {1'b0, pos} + 25'(f[32:24]);
    frac = f[23:0];
    cnt = (count == 0) ? 24'd1 : count;
    fin = 0;
    if (p >= {1'b0, cnt}) begin
      if (loop_en) p = p % {1'b0, cnt};
      else begin
        p = '0; fin = 1;
      end
    end
    pos = p[23:0];
    pending.push_back({fin, pos, mix_one(ar, d[79:56]), mix_one(al, d[55:32])});
  endfunction

  function void check_result(logic [71:0] d, logic fin);
    logic [72:0] e;
    if (pending.size() == 0) begin
      report("unexpected result", 0, d);
      return;
    end
    e = pending.pop_front();
    ticks++;
    if (d[23:0] != e[23:0]) report("out_left", e[23:0], d[23:0]);
    if (d[47:24] != e[47:24]) report("out_right", e[47:24], d[47:24]);
    if (d[71:48] != e[71:48]) report("fetch_position", e[71:48], d[71:48]);
    if (fin != e[72]) report("finished", e[72], fin);
  endfunction

  function void report(string what, logic [71:0] exp_v, logic [71:0] got);
    errors++;
    if (errors <= 30) $display("mismatch %s: expected %0h got %0h", what, exp_v, got);
  endfunction
endclass

module polyphase_fir_resampler_stereo_top_tb;
  import rsmp_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [71:0]  m_tdata;
  logic         m_tuser;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_index_i = '0;
  logic [31:0]  cfg_data_i = '0;

  mix_scoreboard sb = new();
  int  idle_cycles = 0;
  int  hold_off = 0;
  bit  stall_mode = 0;

  polyphase_fir_resampler_stereo_top dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // note accepted requests and results at each edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) sb.note_request(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("timeout waiting for handshakes");
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // receiver: own stall pattern, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 0;
    end else if (stall_mode) m_tready <= ($urandom_range(0, 3) != 0);
    else m_tready <= 1;
  end

  // drop any offered request, then write one register
  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    s_tvalid <= 0;
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.write_reg(idx, v);
  endtask

  // offer one request and hold it until accepted, with random gaps
  task automatic send(logic [1:0] kind, logic [111:0] d);
    if ($urandom_range(0, 7) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_tvalid <= 1; s_tuser <= kind; s_tdata <= d;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_coef(logic [13:0] a, logic [15:0] c);
    send(KIND_COEF, {2'b00, c, a, 80'd0});
  endtask

  // random tick data, extremes now and then
  function automatic logic [111:0] tick_data();
    logic [15:0] sl, sr;
    logic [23:0] ml, mr;
    sl = 16'($urandom); sr = 16'($urandom); ml = 24'($urandom); mr = 24'($urandom);
    if ($urandom_range(0, 7) == 0) ml = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    if ($urandom_range(0, 7) == 0) mr = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
    if ($urandom_range(0, 7) == 0) sl = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    return {32'd0, mr, ml, sr, sl};
  endfunction

  // fill a coefficient row so later ticks may use that phase
  task automatic load_row(int r, bit extreme);
    for (int t = 0; t < 16; t++)
      send_coef(14'(r * 16 + t), extreme ? (t[0] ? 16'h8000 : 16'h7FFF) : 16'($urandom));
  endtask

  // wait out all results and the block's own latency
  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // pick an increment whose phases stay in loaded rows (a quarter step each)
  function automatic logic [31:0] pick_inc(int r);
    return {8'($urandom_range(0, 3)), 2'(r), 22'd0};
  endfunction

  initial begin
    int r;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // load the four rows that quarter-step fractions can reach
    for (int i = 0; i < 4; i++) load_row(i * 256, i == 0 || i == 3);
    stall_mode = 1;

    // directed: registers at extremes, ticks with saturating mixes
    write_reg(REG_GAIN, 32'hFFFF);
    write_reg(REG_COUNT, 32'd5);
    write_reg(REG_LOOP, 32'd0);
    write_reg(REG_STEREO, 32'd0);
    write_reg(REG_INC, 32'h0180_0000);
    for (int i = 0; i < 12; i++) send(KIND_TICK, tick_data());
    send(KIND_RESTART, {$urandom, $urandom, $urandom, 16'($urandom)});
    send(2'd3, {$urandom, $urandom, $urandom, 16'($urandom)});
    send_coef(14'h3FFF, 16'h8000);
    for (int i = 0; i < 6; i++) send(KIND_TICK, tick_data());
    drain();
    write_reg(REG_INC, 32'hFFC0_0000);
    write_reg(REG_COUNT, 32'h00FF_FFFF);
    write_reg(REG_LOOP, 32'd1);
    write_reg(REG_STEREO, 32'd1);
    write_reg(REG_GAIN, 32'd0);
    for (int i = 0; i < 4; i++) send(KIND_TICK, tick_data());
    drain();
    write_reg(REG_INC, 32'd0);
    write_reg(REG_COUNT, 32'd0);
    write_reg(REG_GAIN, 32'd4096);
    for (int i = 0; i < 3; i++) send(KIND_TICK, tick_data());

    // long receiver hold-off while ticks keep coming
    hold_off = 400;
    for (int i = 0; i < 10; i++) send(KIND_TICK, tick_data());
    drain();

    // random phases with fresh settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_INC, (ph == 5) ? {8'($urandom), 2'($urandom), 22'd0}
                                   : pick_inc($urandom_range(0, 3)));
      write_reg(REG_COUNT, (ph % 2) ? $urandom_range(1, 9) : $urandom_range(1, 24'hFFFFFF));
      write_reg(REG_LOOP, 32'(ph[0] ^ ph[1]));
      write_reg(REG_GAIN, $urandom_range(0, 65535));
      write_reg(REG_STEREO, 32'(ph != 3));
      stall_mode = (ph != 2);
      for (int i = 0; i < 80; i++) begin
        r = $urandom_range(0, 39);
        if (r == 0) send(KIND_RESTART, {$urandom, $urandom, $urandom, 16'($urandom)});
        else if (r == 1) send_coef(14'($urandom), 16'($urandom));
        else if (r == 2) send(2'd3, tick_data());
        else send(KIND_TICK, tick_data());
      end
      drain();
    end

    $display("covered %0d checked ticks over nine register settings,", sb.ticks);
    $display("with coefficient writes, restarts, mono and loop/stop endings");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire
